// ===== src/tlb_lru_pkg.sv =====
// tlb_lru_pkg: shared types and constants for the lru translation buffer
// used by tlb_lru_array, tlb_lru_replace and tlb_lru_checker; no dependencies
package tlb_lru_pkg;

  // default table depth and capacity register layout
  localparam int            ENTRIES_DEF = 16;
  localparam int            CAP_W       = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // request function codes
  localparam logic FUNC_TOUCH = 1'b0;
  localparam logic FUNC_FILL  = 1'b1;

  // request payload
  typedef struct packed {
    logic        func;
    logic [31:0] vpn;
    logic [31:0] pfn;
  } req_t;

  // result payload
  typedef struct packed {
    logic        hit;
    logic [31:0] frame;
    logic        evicted;
    logic [31:0] evicted_vpn;
  } rsp_t;

endpackage

// ===== src/tlb_lru_array.sv =====
// tlb_lru_array: entry storage, parallel tag compare and exact recency ranks
// depends on tlb_lru_pkg for the request and result types
module tlb_lru_array #(
  parameter int ENTRIES = tlb_lru_pkg::ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [tlb_lru_pkg::CAP_W-1:0] cap_i,
  input  logic                          step_i,
  input  tlb_lru_pkg::req_t             req_i,
  output tlb_lru_pkg::rsp_t             rsp_o
);

  localparam int AGE_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (CNT_W > tlb_lru_pkg::CAP_W) ? CNT_W : tlb_lru_pkg::CAP_W;

  logic [ENTRIES-1:0] valid_r;
  logic [AGE_W-1:0]   age_r   [ENTRIES];
  logic [31:0]        page_r  [ENTRIES];
  logic [31:0]        frame_r [ENTRIES];
  logic [CNT_W-1:0]   count_r;

  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] victim_oh;
  logic [ENTRIES-1:0] free_oh;
  logic [ENTRIES-1:0] target_oh;
  logic [ENTRIES-1:0] inv;
  logic [31:0]        hit_frame;
  logic [31:0]        victim_page;
  logic [AGE_W-1:0]   old_age;
  logic [CMP_W-1:0]   cap_eff;
  logic               hit;
  logic               is_fill;
  logic               fill_ok;
  logic               full;
  logic               do_promote;
  logic               do_insert;
  logic               do_evict;

  // tag compare, victim search and one-hot reads
  always_comb begin
    hit_frame   = '0;
    victim_page = '0;
    old_age     = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]     = valid_r[i] && (page_r[i] == req_i.vpn);
      victim_oh[i] = valid_r[i] && (CNT_W'(age_r[i]) == count_r - CNT_W'(1));
      if (match[i]) begin
        hit_frame = hit_frame | frame_r[i];
        old_age   = old_age | age_r[i];
      end
      if (victim_oh[i]) begin
        victim_page = victim_page | page_r[i];
      end
    end
  end

  // lowest free slot
  assign inv     = ~valid_r;
  assign free_oh = inv & (~inv + ENTRIES'(1));

  // effective capacity, clamped to the table depth
  assign cap_eff = (CMP_W'(cap_i) > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : CMP_W'(cap_i);

  assign hit        = |match;
  assign is_fill    = (req_i.func == tlb_lru_pkg::FUNC_FILL);
  assign fill_ok    = is_fill && (cap_eff != '0);
  assign full       = CMP_W'(count_r) >= cap_eff;
  assign do_promote = hit && (!is_fill || fill_ok);
  assign do_insert  = fill_ok && !hit;
  assign do_evict   = do_insert && full;
  assign target_oh  = do_evict ? victim_oh : free_oh;

  // result
  always_comb begin
    rsp_o.hit         = hit;
    rsp_o.frame       = (hit && !is_fill) ? hit_frame : '0;
    rsp_o.evicted     = do_evict;
    rsp_o.evicted_vpn = do_evict ? victim_page : '0;
  end

  // valid bits, recency ranks and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        age_r[i] <= '0;
      end
    end else if (step_i) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (do_promote) begin
          if (match[i]) begin
            age_r[i] <= '0;
          end else if (valid_r[i] && (age_r[i] < old_age)) begin
            age_r[i] <= age_r[i] + AGE_W'(1);
          end
        end else if (do_insert) begin
          if (target_oh[i]) begin
            valid_r[i] <= 1'b1;
            age_r[i]   <= '0;
          end else if (valid_r[i]) begin
            age_r[i] <= age_r[i] + AGE_W'(1);
          end
        end
      end
      if (do_insert && !do_evict) begin
        count_r <= count_r + CNT_W'(1);
      end
    end
  end

  // page and frame storage
  always_ff @(posedge clk) begin
    if (step_i) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (do_insert && target_oh[i]) begin
          page_r[i]  <= req_i.vpn;
          frame_r[i] <= req_i.pfn;
        end else if (fill_ok && match[i]) begin
          frame_r[i] <= req_i.pfn;
        end
      end
    end
  end

endmodule

// ===== src/tlb_lru_replace.sv =====
// Fully associative translation buffer with exact lru replacement. A request
// is a touch (lookup, marks the page most recent on a hit) or a fill (writes
// a mapping, updating in place or evicting the least recent entry when the
// capacity register is reached; capacity zero disables fills). One request
// is taken every cycle while the output is not stalled; the request is
// registered, then compared against all tags in parallel, and the entry
// array is updated in the same cycle the result is registered. The
// capacity register may only be written while no request is in flight.
// tlb_lru_replace: top level with handshake registers and capacity register
// depends on tlb_lru_pkg and tlb_lru_array
module tlb_lru_replace #(
  parameter int ENTRIES = tlb_lru_pkg::ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [tlb_lru_pkg::CAP_W-1:0] cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tlb_lru_pkg::req_t             in_req,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tlb_lru_pkg::rsp_t             out_rsp
);

  logic [tlb_lru_pkg::CAP_W-1:0] cap_r;
  logic                          in_v_r;
  tlb_lru_pkg::req_t             in_req_r;
  logic                          out_v_r;
  tlb_lru_pkg::rsp_t             out_rsp_r;
  tlb_lru_pkg::rsp_t             rsp_nxt;
  logic                          advance;

  // a request leaves the input register when the result slot is free
  assign advance   = in_v_r && (!out_v_r || out_ready);
  assign in_ready  = !in_v_r || advance;
  assign out_valid = out_v_r;
  assign out_rsp   = out_rsp_r;

  // capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= tlb_lru_pkg::CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  // input and result valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      if (advance) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_req_r <= in_req;
    end
    if (advance) begin
      out_rsp_r <= rsp_nxt;
    end
  end

  tlb_lru_array #(
    .ENTRIES (ENTRIES)
  ) u_array (
    .clk    (clk),
    .rst_n  (rst_n),
    .cap_i  (cap_r),
    .step_i (advance),
    .req_i  (in_req_r),
    .rsp_o  (rsp_nxt)
  );

endmodule

// ===== src/tlb_lru_checker.sv =====
// tlb_lru_checker: port-level assertions for tlb_lru_replace, bound below
// depends on tlb_lru_pkg and the tlb_lru_replace ports
module tlb_lru_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input tlb_lru_pkg::rsp_t out_rsp
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rsp))
    else $error("result changed while stalled");

  // an eviction only happens on a fill of a page that was not resident
  a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.evicted |-> !out_rsp.hit && (out_rsp.frame == '0))
    else $error("eviction reported with a hit or a frame");

  // a frame or an evicted page is only reported with its flag
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_rsp.frame == '0) || out_rsp.hit) &&
                  ((out_rsp.evicted_vpn == '0) || out_rsp.evicted))
    else $error("unflagged result field not zero");

  // an accepted request reaches the output when the output is drained while it waits in the input register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 out_ready |=> out_valid)
    else $error("result missing after request");

endmodule

bind tlb_lru_replace tlb_lru_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_rsp   (out_rsp)
);

// ===== sim/testbench.sv =====
// testbench for tlb_lru_replace: random and directed touch and fill requests
// checked against an lru table mirror; depends on tlb_lru_pkg and the rtl
`timescale 1ns / 1ps

module testbench;

  localparam int SLOTS      = tlb_lru_pkg::ENTRIES_DEF;
  localparam int POOL_SIZE  = 24;
  localparam int STALL_LIMIT = 5000;

  // mirror of the table contents and recency order, with expected results
  class tlb_mirror;
    bit                            valid[SLOTS];
    logic [31:0]                   page[SLOTS];
    logic [31:0]                   frame[SLOTS];
    int unsigned                   rank[SLOTS];
    logic [tlb_lru_pkg::CAP_W-1:0] cap_reg;
    tlb_lru_pkg::rsp_t             expected_rsp[$];
    int                            errors;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        valid[i] = 1'b0;
        page[i]  = '0;
        frame[i] = '0;
        rank[i]  = 0;
      end
      cap_reg = tlb_lru_pkg::CAP_RESET;
      errors  = 0;
    endfunction

    function void set_capacity(logic [tlb_lru_pkg::CAP_W-1:0] v);
      cap_reg = v;
    endfunction

    // slot s becomes most recent, younger entries age by one
    function void make_recent(int s);
      int unsigned old_rank;
      old_rank = rank[s];
      for (int j = 0; j < SLOTS; j++)
        if (j != s && valid[j] && rank[j] < old_rank) rank[j]++;
      rank[s] = 0;
    endfunction

    function void note_request(tlb_lru_pkg::req_t r);
      tlb_lru_pkg::rsp_t want;
      int                s;
      int                used;
      int                free_slot;
      int                victim;
      int unsigned       lim;
      want = '0;
      lim  = (cap_reg > SLOTS) ? SLOTS : cap_reg;
      s    = -1;
      for (int i = 0; i < SLOTS; i++)
        if (s < 0 && valid[i] && page[i] == r.vpn) s = i;
      want.hit = (s >= 0);
      if (r.func == tlb_lru_pkg::FUNC_TOUCH) begin
        if (s >= 0) begin
          want.frame = frame[s];
          make_recent(s);
        end
      end else if (lim > 0) begin
        if (s >= 0) begin
          frame[s] = r.pfn;
          make_recent(s);
        end else begin
          used      = 0;
          free_slot = -1;
          victim    = -1;
          for (int j = 0; j < SLOTS; j++) begin
            if (valid[j]) begin
              used++;
              if (victim < 0 || rank[j] > rank[victim]) victim = j;
            end else if (free_slot < 0) begin
              free_slot = j;
            end
          end
          // full at the active capacity: drop the least recent entry
          if (used >= lim && victim >= 0) begin
            want.evicted     = 1'b1;
            want.evicted_vpn = page[victim];
            valid[victim]    = 1'b0;
            free_slot        = victim;
          end
          if (free_slot >= 0) begin
            for (int j = 0; j < SLOTS; j++)
              if (valid[j]) rank[j]++;
            valid[free_slot] = 1'b1;
            page[free_slot]  = r.vpn;
            frame[free_slot] = r.pfn;
            rank[free_slot]  = 0;
          end
        end
      end
      expected_rsp = {expected_rsp, want};
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_result(tlb_lru_pkg::rsp_t r);
      tlb_lru_pkg::rsp_t want;
      if (expected_rsp.size() == 0) begin
        report_mismatch("unexpected result", 32'(r.hit), 32'h0);
      end else begin
        want = expected_rsp.pop_front();
        if (r.hit !== want.hit) report_mismatch("hit", 32'(r.hit), 32'(want.hit));
        if (r.frame !== want.frame) report_mismatch("frame", r.frame, want.frame);
        if (r.evicted !== want.evicted)
          report_mismatch("evicted", 32'(r.evicted), 32'(want.evicted));
        if (r.evicted_vpn !== want.evicted_vpn)
          report_mismatch("evicted_vpn", r.evicted_vpn, want.evicted_vpn);
      end
    endtask
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [tlb_lru_pkg::CAP_W-1:0] cfg_wdata;
  logic                          in_valid;
  logic                          in_ready;
  tlb_lru_pkg::req_t             in_req;
  logic                          out_valid;
  logic                          out_ready = 1'b1;
  tlb_lru_pkg::rsp_t             out_rsp;

  logic                          idle_on;
  int                            stall_left = 0;
  int                            quiet_cycles = 0;
  logic [31:0]                   page_pool[POOL_SIZE];
  tlb_mirror                     mirror = new();

  tlb_lru_replace uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_rsp  (out_rsp)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result side back-pressure in bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // accepted requests and results
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) mirror.note_request(in_req);
      if (out_valid && out_ready) mirror.check_result(out_rsp);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // present one request, optionally after an idle burst, hold until taken
  task send_request(input logic func, input logic [31:0] vpn, input logic [31:0] pfn);
    tlb_lru_pkg::req_t r;
    r.func = func;
    r.vpn  = vpn;
    r.pfn  = pfn;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (!in_ready);
  endtask

  // stop sending and wait for every expected result
  task drain;
    in_valid <= 1'b0;
    do @(negedge clk); while (mirror.expected_rsp.size() != 0);
  endtask

  task write_capacity(input logic [tlb_lru_pkg::CAP_W-1:0] v);
    drain();
    repeat (3) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    mirror.set_capacity(v);
  endtask

  // random requests mostly over a small page pool so hits and evictions occur
  task random_phase(input int count);
    logic        func;
    logic [31:0] vpn;
    // refresh part of the pool, keep the rest resident across phases
    for (int k = 0; k < 8; k++) page_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom();
    for (int n = 0; n < count; n++) begin
      func = $urandom_range(0, 1) ? tlb_lru_pkg::FUNC_FILL : tlb_lru_pkg::FUNC_TOUCH;
      vpn  = ($urandom_range(0, 9) < 8) ? page_pool[$urandom_range(0, POOL_SIZE - 1)]
                                         : $urandom();
      send_request(func, vpn, $urandom());
    end
  endtask

  // main sequence
  initial begin
    logic [tlb_lru_pkg::CAP_W-1:0] caps[10];
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    in_req    <= '0;
    idle_on   <= 1'b0;
    for (int k = 0; k < POOL_SIZE; k++) page_pool[k] = $urandom();
    page_pool[0] = 32'h0000_0000;
    page_pool[1] = 32'hffff_ffff;
    repeat (11) @(posedge clk);
    rst_n   <= 1'b1;
    idle_on <= 1'b1;
    @(posedge clk);

    // empty table, extremes of page and frame, in-place update
    send_request(tlb_lru_pkg::FUNC_TOUCH, 32'h0000_0000, 32'hffff_ffff);
    send_request(tlb_lru_pkg::FUNC_FILL,  32'h0000_0000, 32'hffff_ffff);
    send_request(tlb_lru_pkg::FUNC_FILL,  32'hffff_ffff, 32'h0000_0000);
    send_request(tlb_lru_pkg::FUNC_TOUCH, 32'h0000_0000, 32'h0000_0000);
    send_request(tlb_lru_pkg::FUNC_TOUCH, 32'hffff_ffff, 32'hffff_ffff);
    send_request(tlb_lru_pkg::FUNC_FILL,  32'h0000_0000, 32'h1234_5678);
    send_request(tlb_lru_pkg::FUNC_TOUCH, 32'h0000_0000, 32'h0000_0000);
    send_request(tlb_lru_pkg::FUNC_TOUCH, 32'h5555_5555, 32'h0000_0000);

    // small capacity: evictions of the least recent page
    write_capacity(5'd2);
    send_request(tlb_lru_pkg::FUNC_FILL,  32'ha5a5_a5a5, 32'h5a5a_5a5a);
    send_request(tlb_lru_pkg::FUNC_TOUCH, 32'hffff_ffff, 32'h0000_0000);
    send_request(tlb_lru_pkg::FUNC_FILL,  32'h5a5a_5a5a, 32'ha5a5_a5a5);

    // capacity zero: fills dropped, residents still found
    write_capacity(5'd0);
    send_request(tlb_lru_pkg::FUNC_FILL,  32'h1111_1111, 32'h2222_2222);
    send_request(tlb_lru_pkg::FUNC_TOUCH, 32'ha5a5_a5a5, 32'h0000_0000);
    send_request(tlb_lru_pkg::FUNC_TOUCH, 32'h1111_1111, 32'h0000_0000);

    // capacity above the table size
    write_capacity(5'd31);
    send_request(tlb_lru_pkg::FUNC_FILL, 32'h0000_0001, 32'h0000_0010);
    send_request(tlb_lru_pkg::FUNC_FILL, 32'h0000_0002, 32'h0000_0020);
    send_request(tlb_lru_pkg::FUNC_FILL, 32'h0000_0003, 32'h0000_0030);

    // capacity lowered below occupancy
    write_capacity(5'd1);
    send_request(tlb_lru_pkg::FUNC_FILL,  32'h0000_0004, 32'h0000_0040);
    send_request(tlb_lru_pkg::FUNC_FILL,  32'h0000_0005, 32'h0000_0050);
    send_request(tlb_lru_pkg::FUNC_TOUCH, 32'h0000_0004, 32'h0000_0000);
    send_request(tlb_lru_pkg::FUNC_FILL,  32'h0000_0004, 32'h0000_0044);

    // random phases over several capacity settings, the last without idling
    caps[0] = 5'd16;
    caps[1] = 5'd5;
    caps[2] = 5'd1;
    caps[3] = 5'd31;
    caps[4] = 5'd0;
    caps[5] = 5'd17;
    caps[6] = 5'd2;
    caps[7] = 5'd12;
    caps[8] = 5'($urandom_range(0, 31));
    caps[9] = 5'd16;
    for (int p = 0; p < 10; p++) begin
      write_capacity(caps[p]);
      if (p == 9) idle_on <= 1'b0;
      else idle_on <= ($urandom_range(0, 3) != 0);
      random_phase(83);
    end

    // wait out the remaining results and the pipeline
    drain();
    repeat (8) @(posedge clk);
    if (mirror.errors == 0 && mirror.expected_rsp.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
